@@ hw/rtl/ttpfr_pkg.sv @@
// ----------------------------------------------------------------------------
// ttpfr_pkg
// Shared constants, types and the 5x8 font ROM of the text page renderer.
// ----------------------------------------------------------------------------
package ttpfr_pkg;

  localparam int PAGES_DEF   = 8;
  localparam int COLUMNS_DEF = 128;
  localparam int GLYPH_W     = 5;
  localparam int DRAW_STEPS  = 2 * GLYPH_W;

  localparam logic [7:0] ADVANCE    = 8'd6;
  localparam logic [7:0] LINE_STEP  = 8'd8;
  localparam logic [7:0] NEWLINE    = 8'd10;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_RENDER = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  typedef struct packed {
    logic                          found;
    logic [GLYPH_W-1:0][7:0]       cols;
  } glyph_t;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic draw;
    logic rd_item;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_clear;
    logic in_draw;
    logic in_read;
    logic sweep_last;
    logic step_last;
    logic out_free;
  } sts_t;

  function automatic glyph_t mk_glyph(input logic [7:0] c0, input logic [7:0] c1,
                                      input logic [7:0] c2, input logic [7:0] c3,
                                      input logic [7:0] c4);
    glyph_t g;
    g.found   = 1'b1;
    g.cols[0] = c0;
    g.cols[1] = c1;
    g.cols[2] = c2;
    g.cols[3] = c3;
    g.cols[4] = c4;
    return g;
  endfunction

  function automatic glyph_t font_lookup(input logic [7:0] code);
    glyph_t g;
    g = '0;
    unique case (code)
      8'd48:  g = mk_glyph(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
      8'd49:  g = mk_glyph(8'h44, 8'h42, 8'h7F, 8'h40, 8'h40);
      8'd50:  g = mk_glyph(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      8'd51:  g = mk_glyph(8'h22, 8'h41, 8'h49, 8'h49, 8'h36);
      8'd52:  g = mk_glyph(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
      8'd53:  g = mk_glyph(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      8'd54:  g = mk_glyph(8'h3E, 8'h49, 8'h49, 8'h49, 8'h32);
      8'd55:  g = mk_glyph(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      8'd56:  g = mk_glyph(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      8'd57:  g = mk_glyph(8'h26, 8'h49, 8'h49, 8'h49, 8'h3E);
      8'd65:  g = mk_glyph(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
      8'd73:  g = mk_glyph(8'h00, 8'h00, 8'h7F, 8'h00, 8'h00);
      8'd79:  g = mk_glyph(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
      8'd80:  g = mk_glyph(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
      8'd82:  g = mk_glyph(8'h7F, 8'h09, 8'h09, 8'h09, 8'h76);
      8'd83:  g = mk_glyph(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
      8'd85:  g = mk_glyph(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
      8'd86:  g = mk_glyph(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
      8'd87:  g = mk_glyph(8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F);
      8'd97:  g = mk_glyph(8'h20, 8'h54, 8'h54, 8'h54, 8'h78);
      8'd101: g = mk_glyph(8'h38, 8'h54, 8'h54, 8'h54, 8'h18);
      8'd102: g = mk_glyph(8'h08, 8'h7E, 8'h09, 8'h01, 8'h02);
      8'd103: g = mk_glyph(8'h18, 8'hA4, 8'hA4, 8'hA4, 8'h7C);
      8'd105: g = mk_glyph(8'h00, 8'h44, 8'h7D, 8'h40, 8'h00);
      8'd108: g = mk_glyph(8'h00, 8'h00, 8'h7F, 8'h00, 8'h00);
      8'd109: g = mk_glyph(8'h7C, 8'h04, 8'h78, 8'h04, 8'h7C);
      8'd110: g = mk_glyph(8'h7C, 8'h08, 8'h04, 8'h04, 8'h78);
      8'd115: g = mk_glyph(8'h48, 8'h54, 8'h54, 8'h54, 8'h20);
      8'd116: g = mk_glyph(8'h04, 8'h3F, 8'h44, 8'h40, 8'h20);
      8'd122: g = mk_glyph(8'h44, 8'h64, 8'h54, 8'h4C, 8'h44);
      8'd32:  g = mk_glyph(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd44:  g = mk_glyph(8'h00, 8'hA0, 8'h60, 8'h00, 8'h00);
      8'd58:  g = mk_glyph(8'h00, 8'h6C, 8'h6C, 8'h00, 8'h00);
      8'd45:  g = mk_glyph(8'h00, 8'h10, 8'h10, 8'h10, 8'h00);
      8'd46:  g = mk_glyph(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

@@ hw/rtl/ttpfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// ttpfr_ctrl
// Sequencer: initial and clear store sweeps, item dispatch, draw steps, store read and result hand-off.
// ----------------------------------------------------------------------------
module ttpfr_ctrl
  import ttpfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CLEAR = 6'b000100,
    S_DRAW  = 6'b001000,
    S_READ  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          priority if (sts.in_clear) begin
            state_next = S_CLEAR;
          end else if (sts.in_draw) begin
            state_next = S_DRAW;
          end else if (sts.in_read) begin
            state_next = S_READ;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_DRAW: begin
        cmd.draw = 1'b1;
        if (sts.step_last) begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd_item = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

@@ hw/rtl/ttpfr_dp.sv @@
// ----------------------------------------------------------------------------
// ttpfr_dp
// Datapath: frame store, cursor, glyph read-modify-write and result register.
// ----------------------------------------------------------------------------
module ttpfr_dp
  import ttpfr_pkg::*;
#(
  parameter int PAGES   = PAGES_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [1:0] kind,
  input  logic [7:0] char_code,
  input  logic [2:0] read_page,
  input  logic [6:0] read_column,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       glyph_drawn,
  output logic [7:0] cursor_row,
  output logic [7:0] cursor_column
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int AW    = PW + CW;
  localparam int DEPTH = 1 << AW;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_q;

  logic [1:0]    kind_q;
  logic [2:0]    rpage_q;
  logic [6:0]    rcol_q;
  glyph_t        glyph_in;
  glyph_t        glyph_q;
  logic [7:0]    cur_row;
  logic [7:0]    cur_col;
  logic [AW-1:0] sweep_addr;
  logic [3:0]    step;

  logic          op_vld_q;
  logic [AW-1:0] op_addr_q;
  logic [7:0]    op_data_q;
  logic [7:0]    op_mask_q;

  // draw step decode
  logic [2:0]    gx;
  logic [8:0]    dcol;
  logic [5:0]    dpage;
  logic [2:0]    sh;
  logic [15:0]   wbits;
  logic [15:0]   wmask;
  logic          op_ok;
  logic [AW-1:0] draw_addr;
  logic [7:0]    draw_data;
  logic [7:0]    draw_mask;

  logic [5:0]    rp_x;
  logic [8:0]    rc_x;
  logic          rd_ok;
  logic [AW-1:0] item_addr;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic [7:0]    row_next;
  logic [7:0]    col_next;

  assign glyph_in = font_lookup(char_code);

  assign sts.in_clear   = (kind == KIND_CLEAR);
  assign sts.in_draw    = (kind == KIND_RENDER) && glyph_in.found;
  assign sts.in_read    = (kind == KIND_READ);
  assign sts.sweep_last = &sweep_addr;
  assign sts.step_last  = (step == 4'(DRAW_STEPS - 1));
  assign sts.out_free   = !out_valid || out_ready;

  always_comb begin
    gx        = step[3:1];
    dcol      = {1'b0, cur_col} + 9'(gx);
    dpage     = {1'b0, cur_row[7:3]} + 6'(step[0]);
    sh        = cur_row[2:0];
    wbits     = {8'h00, glyph_q.cols[gx]} << sh;
    wmask     = 16'h00FF << sh;
    op_ok     = (dcol < 9'(COLUMNS)) && (dpage < 6'(PAGES)) && (!step[0] || (sh != 3'd0));
    draw_addr = {dpage[PW-1:0], dcol[CW-1:0]};
    draw_data = step[0] ? wbits[15:8] : wbits[7:0];
    draw_mask = step[0] ? wmask[15:8] : wmask[7:0];
  end

  assign rp_x      = 6'(rpage_q);
  assign rc_x      = 9'(rcol_q);
  assign rd_ok     = (rp_x < 6'(PAGES)) && (rc_x < 9'(COLUMNS));
  assign item_addr = {rp_x[PW-1:0], rc_x[CW-1:0]};

  always_comb begin
    mem_we    = cmd.sweep || op_vld_q;
    mem_waddr = cmd.sweep ? sweep_addr : op_addr_q;
    mem_wdata = cmd.sweep ? 8'h00 : ((rd_q & ~op_mask_q) | (op_data_q & op_mask_q));
    mem_re    = cmd.draw || cmd.rd_item;
    mem_raddr = cmd.draw ? draw_addr : item_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      step       <= '0;
      op_vld_q   <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_addr <= sweep_addr + 1'b1;
      end
      if (cmd.accept) begin
        step <= '0;
      end else if (cmd.draw) begin
        step <= step + 4'd1;
      end
      op_vld_q <= cmd.draw && op_ok;
    end
  end

  always_ff @(posedge clk) begin
    op_addr_q <= draw_addr;
    op_data_q <= draw_data;
    op_mask_q <= draw_mask;
    if (cmd.accept) begin
      kind_q  <= kind;
      rpage_q <= read_page;
      rcol_q  <= read_column;
      glyph_q <= glyph_in;
    end
  end

  always_comb begin
    row_next = cur_row;
    col_next = cur_col;
    unique case (kind_q)
      KIND_CLEAR: begin
        row_next = '0;
        col_next = '0;
      end
      KIND_RENDER: begin
        col_next = cur_col + ADVANCE;
      end
      default: begin
        row_next = cur_row;
        col_next = cur_col;
      end
    endcase
  end

  logic is_newline_q;
  logic [7:0] code_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      code_q <= char_code;
    end
  end

  assign is_newline_q = (kind_q == KIND_RENDER) && (code_q == NEWLINE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row   <= '0;
      cur_col   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.finish) begin
        if (is_newline_q) begin
          cur_row <= cur_row + LINE_STEP;
          cur_col <= '0;
        end else begin
          cur_row <= row_next;
          cur_col <= col_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      read_data   <= ((kind_q == KIND_READ) && rd_ok) ? rd_q : 8'h00;
      glyph_drawn <= (kind_q == KIND_RENDER) && glyph_q.found;
      if (is_newline_q) begin
        cursor_row    <= cur_row + LINE_STEP;
        cursor_column <= '0;
      end else begin
        cursor_row    <= row_next;
        cursor_column <= col_next;
      end
    end
  end

endmodule

@@ hw/rtl/text_to_page_framebuffer_renderer.sv @@
// ----------------------------------------------------------------------------
// text_to_page_framebuffer_renderer
// 5x8 character generator drawing into a page-organised monochrome store.
//
// Input channel (in_valid/in_ready) carries one item per transfer: kind 0
// clears the store and homes the cursor, kind 1 renders char_code at the
// cursor (code 10 is a newline), kind 2 reads the store byte at
// read_page/read_column, kind 3 does nothing. Every item gives exactly one
// result transfer on out_valid/out_ready with read_data, glyph_drawn and the
// cursor after the item.
// Items are handled one at a time. A drawn glyph takes ten store
// read-modify-write steps (two page bytes per glyph column, on one write
// port); a clear sweeps the store one byte per cycle. The next input is
// taken in the cycle after the result is loaded into the output register.
// After reset the same sweep zeroes the store with in_ready low. A stalled
// receiver holds the result in the output register; the next item is still
// taken and processed, and its result then waits with in_ready low until
// the register is free.
// ----------------------------------------------------------------------------
module text_to_page_framebuffer_renderer
  import ttpfr_pkg::*;
#(
  parameter int PAGES   = PAGES_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] char_code,
  input  logic [2:0] read_page,
  input  logic [6:0] read_column,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       glyph_drawn,
  output logic [7:0] cursor_row,
  output logic [7:0] cursor_column
);

  cmd_t cmd;
  sts_t sts;

  ttpfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttpfr_dp #(
    .PAGES   (PAGES),
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .kind          (kind),
    .char_code     (char_code),
    .read_page     (read_page),
    .read_column   (read_column),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_data     (read_data),
    .glyph_drawn   (glyph_drawn),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.sweep, cmd.draw, cmd.rd_item, cmd.finish}))
    else $error("more than one datapath command at once");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("result load did not raise out_valid");

  a_draw_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.draw && sts.step_last |=> !cmd.draw)
    else $error("draw ran past its last step");

  a_init_busy: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("input taken before the store sweep");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench for text_to_page_framebuffer_renderer
// Text strings, newlines, unknown codes and store reads are fed through the
// input channel with random gaps. A random receiver stall sits on the result
// channel. Each transfer in is run through a behavioral page store and cursor
// model. Each result transfer is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench;
  import ttpfr_pkg::*;

  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam int STORE_BYTES  = PAGES_DEF * COLUMNS_DEF;
  localparam int PIXEL_ROWS   = PAGES_DEF * 8;
  localparam int GLYPH_COUNT  = 35;
  localparam int ITEM_TARGET  = 1550;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [2:0] read_page;
    logic [6:0] read_column;
  } page_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       glyph_drawn;
    logic [7:0] cursor_row;
    logic [7:0] cursor_column;
  } page_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] kind = '0;
  logic [7:0] char_code = '0;
  logic [2:0] read_page = '0;
  logic [6:0] read_column = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] read_data;
  logic       glyph_drawn;
  logic [7:0] cursor_row;
  logic [7:0] cursor_column;

  // font codes and their five column bytes, column 0 in the top byte
  logic [7:0] glyph_codes [GLYPH_COUNT] = '{
    8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57,
    8'd65, 8'd73, 8'd79, 8'd80, 8'd82, 8'd83, 8'd85, 8'd86, 8'd87,
    8'd97, 8'd101, 8'd102, 8'd103, 8'd105, 8'd108, 8'd109, 8'd110, 8'd115,
    8'd116, 8'd122, 8'd32, 8'd44, 8'd58, 8'd45, 8'd46
  };
  logic [39:0] glyph_bits [GLYPH_COUNT] = '{
    40'h3E5149453E, 40'h44427F4040, 40'h4261514946, 40'h2241494936,
    40'h1814127F10, 40'h2745454539, 40'h3E49494932, 40'h0171090503,
    40'h3649494936, 40'h264949493E, 40'h7E1111117E, 40'h00007F0000,
    40'h3E4141413E, 40'h7F09090906, 40'h7F09090976, 40'h4649494931,
    40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F, 40'h2054545478,
    40'h3854545418, 40'h087E090102, 40'h18A4A4A47C, 40'h00447D4000,
    40'h00007F0000, 40'h7C0478047C, 40'h7C08040478, 40'h4854545420,
    40'h043F444020, 40'h4464544C44, 40'h0000000000, 40'h00A0600000,
    40'h006C6C0000, 40'h0010101000, 40'h0060600000
  };

  logic [7:0]   model_store [STORE_BYTES];
  logic [7:0]   model_row = '0;
  logic [7:0]   model_col = '0;
  logic [7:0]   plan_row = '0;
  logic [7:0]   plan_col = '0;
  page_item_t   pending_items [$];
  page_result_t expected_results [$];
  page_item_t   drive_item;
  page_item_t   taken_item;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   in_gap = 0;
  int   in_calm = 0;
  int   out_stall = 0;
  int   out_calm = 0;
  int   error_count = 0;
  int   cycle_count = 0;
  int   items_accepted = 0;
  int   results_checked = 0;
  int   clears_seen = 0;
  int   reads_seen = 0;
  int   glyphs_seen = 0;

  text_to_page_framebuffer_renderer u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .char_code    (char_code),
    .read_page    (read_page),
    .read_column  (read_column),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .glyph_drawn  (glyph_drawn),
    .cursor_row   (cursor_row),
    .cursor_column(cursor_column)
  );

  always #5 clk = ~clk;

  function automatic page_result_t page_model_step(input page_item_t it);
    page_result_t res;
    int hit;
    int i;
    int gy;
    int gx;
    int r;
    int c;
    logic [7:0] col_bits;
    res = '0;
    case (it.kind)
      KIND_CLEAR: begin
        for (i = 0; i < STORE_BYTES; i++) model_store[i] = '0;
        model_row = '0;
        model_col = '0;
      end
      KIND_RENDER: begin
        if (it.char_code == NEWLINE) begin
          model_row = model_row + LINE_STEP;
          model_col = '0;
        end else begin
          hit = -1;
          for (i = 0; i < GLYPH_COUNT; i++)
            if (hit < 0 && glyph_codes[i] == it.char_code) hit = i;
          if (hit >= 0) begin
            // clip at the bottom row and the right edge
            for (gy = 0; gy < 8 && int'(model_row) + gy < PIXEL_ROWS; gy++) begin
              for (gx = 0; gx < GLYPH_W && int'(model_col) + gx < COLUMNS_DEF; gx++) begin
                r = int'(model_row) + gy;
                c = int'(model_col) + gx;
                col_bits = glyph_bits[hit][39 - 8*gx -: 8];
                model_store[(r >> 3) * COLUMNS_DEF + c][r & 7] = col_bits[gy];
              end
            end
            res.glyph_drawn = 1'b1;
          end
          model_col = model_col + ADVANCE;
        end
      end
      KIND_READ: begin
        if (it.read_page < PAGES_DEF && it.read_column < COLUMNS_DEF)
          res.read_data = model_store[int'(it.read_page) * COLUMNS_DEF + int'(it.read_column)];
      end
      default: ;
    endcase
    res.cursor_row = model_row;
    res.cursor_column = model_col;
    return res;
  endfunction

  function automatic int draw_gap(inout int calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (roll < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_item(input logic [1:0] k, input logic [7:0] code,
                            input logic [2:0] page, input logic [6:0] column);
    page_item_t it;
    it.kind = k;
    it.char_code = code;
    it.read_page = page;
    it.read_column = column;
    pending_items.push_back(it);
    // track the cursor so that reads can be aimed at fresh glyphs
    if (k == KIND_CLEAR) begin
      plan_row = '0;
      plan_col = '0;
    end else if (k == KIND_RENDER && code == NEWLINE) begin
      plan_row = plan_row + LINE_STEP;
      plan_col = '0;
    end else if (k == KIND_RENDER) begin
      plan_col = plan_col + ADVANCE;
    end
  endtask

  task automatic queue_aimed_read();
    logic [7:0] column;
    logic [2:0] page;
    column = plan_col - ADVANCE + 8'($urandom_range(0, 5));
    page = (plan_row < PIXEL_ROWS) ? plan_row[5:3] : 3'($urandom_range(0, 7));
    queue_item(KIND_READ, 8'($urandom_range(0, 255)), page, column[6:0]);
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch %0d at cycle %0d: %s", error_count, cycle_count, msg);
  endtask

  task automatic check_result(input page_result_t got);
    page_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result transfer with no item outstanding");
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      if (got.read_data !== want.read_data)
        report_mismatch($sformatf("read_data %h, want %h", got.read_data, want.read_data));
      if (got.glyph_drawn !== want.glyph_drawn)
        report_mismatch($sformatf("glyph_drawn %b, want %b", got.glyph_drawn,
                                  want.glyph_drawn));
      if (got.cursor_row !== want.cursor_row)
        report_mismatch($sformatf("cursor_row %0d, want %0d", got.cursor_row,
                                  want.cursor_row));
      if (got.cursor_column !== want.cursor_column)
        report_mismatch($sformatf("cursor_column %0d, want %0d", got.cursor_column,
                                  want.cursor_column));
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
        kind <= 2'($urandom_range(0, 3));
        char_code <= 8'($urandom_range(0, 255));
        read_page <= 3'($urandom_range(0, 7));
        read_column <= 7'($urandom_range(0, 127));
      end else if (pending_items.size() > 0) begin
        drive_item = pending_items.pop_front();
        in_valid <= 1'b1;
        kind <= drive_item.kind;
        char_code <= drive_item.char_code;
        read_page <= drive_item.read_page;
        read_column <= drive_item.read_column;
        in_gap = draw_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (out_taken || $urandom_range(0, 99) < 4) out_stall = draw_gap(out_calm);
    end
  end

  // monitor
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
    out_taken <= !rst && out_valid && out_ready;
    if (!rst) begin
      if (out_valid && out_ready)
        check_result({read_data, glyph_drawn, cursor_row, cursor_column});
      if (in_valid && in_ready) begin
        taken_item = {kind, char_code, read_page, read_column};
        expected_results.push_back(page_model_step(taken_item));
        items_accepted++;
        if (kind == KIND_CLEAR) clears_seen++;
        if (kind == KIND_READ) reads_seen++;
        if (kind == KIND_RENDER && expected_results[$].glyph_drawn) glyphs_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("[text_to_page_framebuffer_renderer] ERROR");
      $finish;
    end
  end

  initial begin
    int pick;
    int len;
    int n;
    int roll;
    for (n = 0; n < STORE_BYTES; n++) model_store[n] = '0;

    // directed: empty store, no-op, glyphs, misses, newline, clear, bottom clip
    queue_item(KIND_READ, 8'd0, 3'd0, 7'd0);
    queue_item(KIND_READ, 8'hFF, 3'd7, 7'd127);
    queue_item(KIND_NOP, 8'hFF, 3'd7, 7'd127);
    queue_item(KIND_RENDER, 8'd48, 3'd0, 7'd0);
    queue_item(KIND_READ, 8'd0, 3'd0, 7'd0);
    queue_item(KIND_READ, 8'd0, 3'd0, 7'd4);
    queue_item(KIND_READ, 8'd0, 3'd0, 7'd5);
    queue_item(KIND_RENDER, 8'd103, 3'd0, 7'd0);
    queue_item(KIND_READ, 8'd0, 3'd0, 7'd7);
    queue_item(KIND_RENDER, 8'd0, 3'd0, 7'd0);
    queue_item(KIND_RENDER, 8'hFF, 3'd0, 7'd0);
    queue_item(KIND_RENDER, NEWLINE, 3'd0, 7'd0);
    queue_item(KIND_RENDER, 8'd65, 3'd0, 7'd0);
    queue_item(KIND_READ, 8'd0, 3'd1, 7'd0);
    queue_item(KIND_CLEAR, 8'hFF, 3'd7, 7'd127);
    queue_item(KIND_READ, 8'd0, 3'd0, 7'd0);
    repeat (8) queue_item(KIND_RENDER, NEWLINE, 3'd0, 7'd0);
    queue_item(KIND_RENDER, 8'd87, 3'd0, 7'd0);
    queue_item(KIND_READ, 8'd0, 3'd7, 7'd0);

    while (pending_items.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        queue_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                   7'($urandom_range(0, 127)));
      end else if (pick < 63) begin
        // a line of text, sometimes long enough to clip and wrap the column
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 20);
        for (n = 0; n < len; n++) begin
          roll = $urandom_range(0, 99);
          if (roll < 88)
            queue_item(KIND_RENDER, glyph_codes[$urandom_range(0, GLYPH_COUNT - 1)],
                       3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
          else
            queue_item(KIND_RENDER, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                       7'($urandom_range(0, 127)));
          if ($urandom_range(0, 99) < 25) queue_aimed_read();
        end
        if ($urandom_range(0, 99) < 70)
          queue_item(KIND_RENDER, NEWLINE, 3'($urandom_range(0, 7)),
                     7'($urandom_range(0, 127)));
      end else if (pick < 78) begin
        repeat ($urandom_range(1, 8))
          queue_item(KIND_READ, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                     7'($urandom_range(0, 127)));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4))
          queue_item(KIND_RENDER, NEWLINE, 3'($urandom_range(0, 7)),
                     7'($urandom_range(0, 127)));
      end else if (pick < 93) begin
        queue_item(KIND_NOP, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                   7'($urandom_range(0, 127)));
      end else begin
        queue_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("ran %0d items: %0d clears, %0d reads, %0d glyphs drawn",
             items_accepted, clears_seen, reads_seen, glyphs_seen);
    $display("checked %0d results in %0d cycles, %0d mismatches",
             results_checked, cycle_count, error_count);
    if (error_count == 0) begin
      $display("[text_to_page_framebuffer_renderer] OK");
    end else begin
      $display("[text_to_page_framebuffer_renderer] ERROR");
    end
    $finish;
  end

endmodule
